>>> src/ptts_pkg.sv
// shared types, codes and sizes for the periodic task tick scheduler
// no dependencies
package ptts_pkg;

	localparam int DEF_NUM_SLOTS = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int CMD_DEPTH     = 2;
	localparam int RES_DEPTH     = 2;

	localparam int ACTION_W = 3;
	localparam int SLOT_W   = 4;
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 2;
	localparam int TIDX_W   = 3;
	localparam int NF_W     = $clog2(MAX_RESULTS + 1);

	localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SUSPEND = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_RESUME  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_TAKEN     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NO_TASK   = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [SLOT_W-1:0]   slot;
		logic [DATA_W-1:0]   period;
		logic [DATA_W-1:0]   first_delay;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                fired;
		logic [TIDX_W-1:0]   task_index;
		logic                last;
	} result_t;

	typedef enum logic [2:0] {
		CMD_CREATE,
		CMD_DELETE,
		CMD_SUSPEND,
		CMD_RESUME,
		CMD_TICK,
		CMD_BAD,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] period;
		logic [DATA_W-1:0] first_delay;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DONE
	} back_state_t;

endpackage

>>> src/ptts_fifo.sv
// small synchronous queue of any packed type
// depends on nothing but its type parameter
module ptts_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     din,
	output logic full,
	input  logic rd,
	output T     dout,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

>>> src/ptts_front.sv
// front end: accepts items, sorts them into commands, queues them for the back end
// depends on ptts_pkg and ptts_fifo
module ptts_front import ptts_pkg::*; #(
	parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	input  logic  cmd_pop,
	output logic  cmd_empty,
	output cmd_t  cmd
);

	cmd_t cls;
	logic bad_slot;

	// one extra bit so a table of sixteen slots compares correctly
	assign bad_slot = ({1'b0, item.slot} >= (SLOT_W + 1)'(NUM_SLOTS));

	always_comb begin
		cls.slot        = item.slot;
		cls.period      = item.period;
		cls.first_delay = item.first_delay;
		unique case (item.action)
			ACT_CREATE:  cls.kind = bad_slot ? CMD_BAD : CMD_CREATE;
			ACT_DELETE:  cls.kind = bad_slot ? CMD_BAD : CMD_DELETE;
			ACT_SUSPEND: cls.kind = bad_slot ? CMD_BAD : CMD_SUSPEND;
			ACT_RESUME:  cls.kind = bad_slot ? CMD_BAD : CMD_RESUME;
			ACT_TICK:    cls.kind = CMD_TICK;
			default:     cls.kind = CMD_NOP;
		endcase
	end

	ptts_fifo #(.T(cmd_t), .DEPTH(CMD_DEPTH)) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.din   (cls),
		.full  (full),
		.rd    (cmd_pop),
		.dout  (cmd),
		.empty (cmd_empty)
	);

endmodule

>>> src/ptts_back.sv
// back end: slot table and the sequencer that runs commands and tick scans
// depends on ptts_pkg
module ptts_back import ptts_pkg::*; #(
	parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_empty,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	back_state_t state_q, state_d;

	logic              valid_q [NUM_SLOTS];
	logic              run_q   [NUM_SLOTS];
	logic [DATA_W-1:0] per_q   [NUM_SLOTS];
	logic [DATA_W-1:0] cnt_q   [NUM_SLOTS];

	logic [IDX_W-1:0] scan_q;
	logic [NF_W-1:0]  nfire_q;
	logic             pend_v_q;
	logic [IDX_W-1:0] pend_idx_q;

	logic [IDX_W-1:0]  addr;
	logic              rd_valid, rd_run, is_live, is_due, report;
	logic [DATA_W-1:0] rd_per, rd_cnt;
	logic              go, tick_start, scan_end;

	logic              flag_we, wr_valid, wr_run;
	logic              per_we, cnt_we;
	logic [DATA_W-1:0] wr_per, wr_cnt;

	// one table port, shared by command handling and the scan
	assign addr     = (state_q == BK_SCAN) ? scan_q : cmd.slot[IDX_W-1:0];
	assign rd_valid = valid_q[addr];
	assign rd_run   = run_q[addr];
	assign rd_per   = per_q[addr];
	assign rd_cnt   = cnt_q[addr];
	assign is_live  = rd_valid && rd_run;
	assign is_due   = is_live && (rd_cnt == '0);
	assign report   = is_due && (nfire_q < NF_W'(MAX_RESULTS));

	assign go         = !cmd_empty && !res_full;
	assign tick_start = (state_q == BK_IDLE) && go && (cmd.kind == CMD_TICK);
	assign scan_end   = (scan_q == IDX_W'(NUM_SLOTS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (tick_start) state_d = BK_SCAN;
			end
			BK_SCAN: begin
				if (!res_full && scan_end) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (!res_full) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '{status: STAT_OK, fired: 1'b0, task_index: '0, last: 1'b1};
		flag_we  = 1'b0;
		wr_valid = 1'b0;
		wr_run   = 1'b0;
		per_we   = 1'b0;
		wr_per   = '0;
		cnt_we   = 1'b0;
		wr_cnt   = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (go) begin
					cmd_pop  = 1'b1;
					res_push = (cmd.kind != CMD_TICK);
					unique case (cmd.kind)
						CMD_TICK, CMD_NOP: ;
						CMD_BAD: res.status = STAT_BAD_INDEX;
						CMD_CREATE: begin
							if (rd_valid) begin
								res.status = STAT_TAKEN;
							end else begin
								flag_we  = 1'b1;
								wr_valid = 1'b1;
								wr_run   = 1'b1;
								per_we   = 1'b1;
								wr_per   = cmd.period;
								cnt_we   = 1'b1;
								wr_cnt   = cmd.first_delay;
							end
						end
						CMD_DELETE, CMD_SUSPEND, CMD_RESUME: begin
							if (!rd_valid) begin
								res.status = STAT_NO_TASK;
							end else begin
								flag_we  = 1'b1;
								wr_valid = (cmd.kind != CMD_DELETE);
								wr_run   = (cmd.kind == CMD_RESUME);
								per_we   = (cmd.kind == CMD_DELETE);
								cnt_we   = (cmd.kind == CMD_DELETE);
							end
						end
						default: ;
					endcase
				end
			end
			BK_SCAN: begin
				if (!res_full) begin
					cnt_we = is_live;
					wr_cnt = is_due ? rd_per : rd_cnt - 1'b1;
					// a held fire goes out once a later one proves it is not the last
					if (report && pend_v_q) begin
						res_push       = 1'b1;
						res.fired      = 1'b1;
						res.task_index = TIDX_W'(pend_idx_q);
						res.last       = 1'b0;
					end
				end
			end
			BK_DONE: begin
				if (!res_full) begin
					res_push       = 1'b1;
					res.fired      = pend_v_q;
					res.task_index = pend_v_q ? TIDX_W'(pend_idx_q) : '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			scan_q   <= '0;
			nfire_q  <= '0;
			pend_v_q <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				valid_q[i] <= 1'b0;
				run_q[i]   <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (flag_we) begin
				valid_q[addr] <= wr_valid;
				run_q[addr]   <= wr_run;
			end
			if (tick_start) begin
				scan_q   <= '0;
				nfire_q  <= '0;
				pend_v_q <= 1'b0;
			end else if (state_q == BK_SCAN && !res_full) begin
				if (!scan_end) scan_q <= scan_q + 1'b1;
				if (report) begin
					nfire_q  <= nfire_q + 1'b1;
					pend_v_q <= 1'b1;
				end
			end else if (state_q == BK_DONE && !res_full) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (per_we) per_q[addr] <= wr_per;
		if (cnt_we) cnt_q[addr] <= wr_cnt;
		if (state_q == BK_SCAN && !res_full && report) pend_idx_q <= scan_q;
	end

endmodule

>>> src/periodic_task_tick_scheduler_top.sv
// a command result goes from the command queue through the back end to the result queue, a
// tick's last result from the done state; the back end holds while the result queue is full
// create, delete, suspend, resume and unused actions: one item per cycle through the back end
// when idle; tick: scan and done states, one table slot visited per cycle by the scanner
// front and back queues hold two entries each and let either side stall on its own
// reset: asynchronous, clears all slots to empty and drains both queues
module periodic_task_tick_scheduler_top import ptts_pkg::*; #(
	parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	cmd_t    cmd;
	logic    cmd_empty, cmd_pop;
	logic    res_full, res_push;
	result_t res;

	ptts_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_pop  (cmd_pop),
		.cmd_empty(cmd_empty),
		.cmd      (cmd)
	);

	ptts_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	ptts_fifo #(.T(result_t), .DEPTH(RES_DEPTH)) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.din   (res),
		.full  (res_full),
		.rd    (pop),
		.dout  (result),
		.empty (empty)
	);

endmodule

>>> sim/tb_periodic_task_tick_scheduler_top.sv
// testbench for periodic_task_tick_scheduler_top: directed and random slot commands and ticks,
// every result checked in order against a shadow slot table kept in a scoreboard class
// depends on ptts_pkg and the top level only
module tb_periodic_task_tick_scheduler_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ptts_pkg::*;

	localparam int SLOTS        = DEF_NUM_SLOTS;
	localparam int RAND_ITEMS   = 380;
	localparam int CYCLE_LIMIT  = 400_000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = SLOTS + 4;
	localparam logic [ACTION_W-1:0] ACT_SPARE_LO = ACT_TICK + 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI = '1;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	bit          hold_req;
	bit          calm;
	int unsigned cycles;

	class sched_tracker;
		bit               valid_tbl[SLOTS];
		bit               run_tbl[SLOTS];
		logic [DATA_W-1:0] period_tbl[SLOTS];
		logic [DATA_W-1:0] count_tbl[SLOTS];
		result_t          due_reports[$];
		int               errors;

		function new();
			foreach (valid_tbl[i]) begin
				valid_tbl[i]  = 1'b0;
				run_tbl[i]    = 1'b0;
				period_tbl[i] = '0;
				count_tbl[i]  = '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return due_reports.size();
		endfunction

		// update the shadow table for one accepted item and queue the reports it causes
		function void apply_item(item_t it);
			result_t r;
			int      n;
			int      s;
			r = '0;
			r.status = STAT_OK;
			r.last = 1'b1;
			s = it.slot;
			if (it.action == ACT_TICK) begin
				n = 0;
				for (int i = 0; i < SLOTS; i++) begin
					if (!valid_tbl[i] || !run_tbl[i])
						continue;
					if (count_tbl[i] == '0) begin
						count_tbl[i] = period_tbl[i];
						if (n < MAX_RESULTS) begin
							r.fired = 1'b1;
							r.task_index = TIDX_W'(i);
							r.last = 1'b0;
							due_reports.push_back(r);
							n++;
						end
					end else begin
						count_tbl[i] = count_tbl[i] - 1'b1;
					end
				end
				if (n == 0)
					due_reports.push_back(r);
				else
					due_reports[due_reports.size() - 1].last = 1'b1;
				return;
			end
			if (it.action < ACT_TICK) begin
				if (s >= SLOTS) begin
					r.status = STAT_BAD_INDEX;
				end else if (it.action == ACT_CREATE) begin
					if (valid_tbl[s]) begin
						r.status = STAT_TAKEN;
					end else begin
						valid_tbl[s]  = 1'b1;
						run_tbl[s]    = 1'b1;
						period_tbl[s] = it.period;
						count_tbl[s]  = it.first_delay;
					end
				end else if (!valid_tbl[s]) begin
					r.status = STAT_NO_TASK;
				end else if (it.action == ACT_DELETE) begin
					valid_tbl[s]  = 1'b0;
					run_tbl[s]    = 1'b0;
					period_tbl[s] = '0;
					count_tbl[s]  = '0;
				end else if (it.action == ACT_SUSPEND) begin
					run_tbl[s] = 1'b0;
				end else begin
					run_tbl[s] = 1'b1;
				end
			end
			due_reports.push_back(r);
		endfunction

		function void field_diff(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void match_report(result_t got);
			result_t want;
			if (due_reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = due_reports.pop_front();
			field_diff("status", 8'(want.status), 8'(got.status));
			field_diff("fired", 8'(want.fired), 8'(got.fired));
			field_diff("task_index", 8'(want.task_index), 8'(got.task_index));
			field_diff("last", 8'(want.last), 8'(got.last));
		endfunction
	endclass

	sched_tracker tracker = new();

	periodic_task_tick_scheduler_top #(
		.NUM_SLOTS(SLOTS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_cycles();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic item_t mk(logic [ACTION_W-1:0] a, int s, int p, int d);
		item_t it;
		it.action      = a;
		it.slot        = SLOT_W'(s);
		it.period      = DATA_W'(p);
		it.first_delay = DATA_W'(d);
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int    pick;
		pick = $urandom_range(0, 99);
		it.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
		// short periods keep tasks firing often
		it.period      = DATA_W'($urandom_range(0, 6));
		it.first_delay = DATA_W'($urandom_range(0, 6));
		if ($urandom_range(0, 9) == 0) begin
			it.period      = DATA_W'($urandom_range(0, 255));
			it.first_delay = DATA_W'($urandom_range(0, 255));
		end
		if (pick < 35) begin
			it.action = ACT_TICK;
		end else if (pick < 60) begin
			it.action = ACT_CREATE;
		end else if (pick < 72) begin
			it.action = ACT_DELETE;
		end else if (pick < 82) begin
			it.action = ACT_SUSPEND;
		end else if (pick < 92) begin
			it.action = ACT_RESUME;
		end else if (pick < 96) begin
			it.action = ACTION_W'($urandom_range(ACT_CREATE, ACT_RESUME));
			it.slot   = SLOT_W'($urandom_range(SLOTS, (1 << SLOT_W) - 1));
		end else begin
			it.action = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
			it.slot   = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		tracker.apply_item(it);
		gap = gap_cycles();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_wait();
		push <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin : result_side
		int stall_left;
		stall_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				tracker.match_report(result);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				stall_left = gap_cycles();
			end
		end
	end

	initial begin : stimulus
		hold_req = 1'b0;
		calm = 1'b0;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: tick with nothing due, commands on empty slots
		send_item(mk(ACT_TICK, 0, 0, 0));
		send_item(mk(ACT_DELETE, 3, 0, 0));
		send_item(mk(ACT_SUSPEND, 0, 0, 0));
		// slot index past the table for each command
		send_item(mk(ACT_CREATE, SLOTS, 8'hff, 8'hff));
		send_item(mk(ACT_DELETE, 15, 0, 0));
		send_item(mk(ACT_SUSPEND, 9, 0, 0));
		send_item(mk(ACT_RESUME, 12, 0, 0));
		// fill every slot due at once, so one tick reports the most fires
		send_item(mk(ACT_CREATE, 0, 0, 0));
		for (int i = 1; i < SLOTS - 1; i++)
			send_item(mk(ACT_CREATE, i, i, 0));
		send_item(mk(ACT_CREATE, SLOTS - 1, 8'hff, 0));
		send_item(mk(ACT_TICK, 0, 0, 0));
		send_item(mk(ACT_CREATE, 0, 5, 5));
		send_item(mk(ACT_TICK, 0, 0, 0));
		// suspended task skips the tick, then comes back
		send_item(mk(ACT_SUSPEND, 0, 0, 0));
		send_item(mk(ACT_TICK, 0, 0, 0));
		send_item(mk(ACT_RESUME, 0, 0, 0));
		send_item(mk(ACT_DELETE, SLOTS - 1, 0, 0));
		send_item(mk(ACT_CREATE, SLOTS - 1, 0, 8'hff));
		send_item(mk(ACT_SPARE_LO, 2, 8'haa, 8'h55));
		send_item(mk(ACT_SPARE_HI, 15, 8'h55, 8'haa));

		for (int k = 0; k < RAND_ITEMS; k++) begin
			// long result-side hold while items keep coming, so the input backs up
			if (k == 120)
				hold_req = 1'b1;
			if (k == 240)
				drain_wait();
			calm = (k >= 300 && k < 340);
			send_item(rand_item());
		end
		calm = 1'b0;

		drain_wait();
		repeat (SETTLE) @(posedge clk);
		if (tracker.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
src/ptts_pkg.sv
src/ptts_fifo.sv
src/ptts_front.sv
src/ptts_back.sv
src/periodic_task_tick_scheduler_top.sv
sim/tb_periodic_task_tick_scheduler_top.sv
